// File: sv/mzof_pkg.sv
// Shared types and constants for the modified z-score outlier filter.
// Holds the payload structs, arithmetic widths and configuration codes.
// No dependencies.
package mzof_pkg;

    // Fixed geometry of one sample set
    localparam int SENSOR_COUNT  = 4;
    localparam int READING_WIDTH = 24;
    localparam int SCALE_WIDTH   = 16;

    // Compare shift: 2 * 2^14 on the deviation side of the outlier test
    localparam int DEV_SHIFT = 15;

    // Product widths: scale * spread, then times seven
    localparam int PROD_WIDTH  = READING_WIDTH + SCALE_WIDTH;
    localparam int PROD7_WIDTH = PROD_WIDTH + 3;

    // Configuration register indexes
    localparam logic CFG_MEDIAN_DEV_SCALE = 1'b0;
    localparam logic CFG_MEAN_DEV_SCALE   = 1'b1;

    // Reset values of the scale registers (Q2.14)
    localparam logic [SCALE_WIDTH-1:0] MEDIAN_DEV_SCALE_RST = 16'd24291;
    localparam logic [SCALE_WIDTH-1:0] MEAN_DEV_SCALE_RST   = 16'd20534;

    typedef logic signed [READING_WIDTH-1:0]   t_reading;
    typedef logic signed [READING_WIDTH:0]     t_sum1;
    typedef logic signed [READING_WIDTH+1:0]   t_sum2;
    typedef logic        [READING_WIDTH-1:0]   t_dev;
    typedef logic        [READING_WIDTH+1:0]   t_dev_sum;
    typedef logic        [SCALE_WIDTH-1:0]     t_scale;
    typedef logic        [PROD_WIDTH-1:0]      t_prod;
    typedef logic        [PROD7_WIDTH-1:0]     t_prod7;
    typedef logic        [SENSOR_COUNT-1:0]    t_flags;

    typedef struct packed {
        t_reading reading_0;
        t_reading reading_1;
        t_reading reading_2;
        t_reading reading_3;
    } t_in_item;

    typedef struct packed {
        t_reading cleaned_0;
        t_reading cleaned_1;
        t_reading cleaned_2;
        t_reading cleaned_3;
        t_flags   reliable_mask;
        t_reading median_value;
    } t_out_item;

endpackage

// File: sv/modified_zscore_outlier_filter.sv
// Modified z-score outlier filter: eight-stage pipeline over four sensor readings.
// Depends on mzof_pkg for payload structs, widths and configuration codes.
//
//   Channel   Signals                                  Direction  Moves
//   input     i_in_valid / o_in_ready / i_in_data      in         one set of four readings
//   output    o_out_valid / i_out_ready / o_out_data   out        cleaned set, mask, median
//   config    i_cfg_we / i_cfg_index / i_cfg_data      in         scale register write
//
// One sample set enters per cycle while the pipeline advances; its result passes through
// the chain sort -> median -> deviations -> sort -> MAD -> multiply -> times seven ->
// compare, one register stage per step, and is offered from the output register. The
// whole pipeline advances together whenever the output register is empty or being
// taken; while the output is held, every stage holds and the input is not ready.
// Reset (synchronous, active low) clears the valid bits and loads the scale registers
// with their defaults.
module modified_zscore_outlier_filter
    import mzof_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SCALE_WIDTH-1:0] i_cfg_data
);

    localparam int STAGES = 8;

    // Absolute difference of two readings
    function automatic t_dev f_absdiff(input t_reading a, input t_reading b);
        t_sum1 diff;
        diff = t_sum1'(a) - t_sum1'(b);
        if (diff < 0) begin
            diff = -diff;
        end
        return diff[READING_WIDTH-1:0];
    endfunction

    // Pipeline control
    logic              en;
    logic [STAGES-1:0] r_vld;

    // Configuration registers
    t_scale r_med_scale;
    t_scale r_mean_scale;

    // Stage 1: captured readings, dead flags, first sort layer, sums
    t_reading n1_x [SENSOR_COUNT];
    t_flags   n1_dead;
    logic [2:0] dead_cnt;
    logic [1:0] live_cnt;
    t_reading live0, live1;
    t_reading n1_min01, n1_max01, n1_min23, n1_max23;
    t_sum1    n1_lsum;
    t_sum2    n1_sum;

    t_reading r1_x [SENSOR_COUNT];
    t_flags   r1_dead;
    logic     r1_two;
    t_reading r1_min01, r1_max01, r1_min23, r1_max23;
    t_sum1    r1_lsum;
    t_sum2    r1_sum;

    // Stage 2: median and mean
    t_reading mid_a, mid_b;
    t_sum1    mid_sum;
    t_reading n2_med;
    t_reading r2_x [SENSOR_COUNT];
    t_flags   r2_dead;
    t_reading r2_med;
    t_reading r2_mean;

    // Stage 3: absolute deviations
    t_dev     r3_dev [SENSOR_COUNT];
    t_dev     r3_adm [SENSOR_COUNT];
    t_reading r3_x [SENSOR_COUNT];
    t_flags   r3_dead;
    t_reading r3_med;

    // Stage 4: first sort layer of deviations, mean-deviation sum
    t_dev     n4_dmin01, n4_dmax01, n4_dmin23, n4_dmax23;
    t_dev_sum n4_adsum;
    t_dev     r4_dmin01, r4_dmax01, r4_dmin23, r4_dmax23;
    t_dev_sum r4_adsum;
    t_dev     r4_dev [SENSOR_COUNT];
    t_reading r4_x [SENSOR_COUNT];
    t_flags   r4_dead;
    t_reading r4_med;

    // Stage 5: MAD and mean absolute deviation
    t_dev     dmid_a, dmid_b;
    logic [READING_WIDTH:0] dmid_sum;
    t_dev     r5_mad;
    t_dev     r5_meanad;
    t_dev     r5_dev [SENSOR_COUNT];
    t_reading r5_x [SENSOR_COUNT];
    t_flags   r5_dead;
    t_reading r5_med;

    // Stage 6: scale times spread
    logic     use_mad;
    t_dev     spread;
    t_scale   scale;
    t_prod    r6_prod;
    logic     r6_quiet;
    t_dev     r6_dev [SENSOR_COUNT];
    t_reading r6_x [SENSOR_COUNT];
    t_flags   r6_dead;
    t_reading r6_med;

    // Stage 7: times seven
    t_prod7   r7_p7;
    logic     r7_quiet;
    t_dev     r7_dev [SENSOR_COUNT];
    t_reading r7_x [SENSOR_COUNT];
    t_flags   r7_dead;
    t_reading r7_med;

    // Stage 8: outlier decision into the output register
    t_reading  cleaned [SENSOR_COUNT];
    t_flags    keep;
    t_out_item n_out;
    t_out_item r_out;

    // Advance the whole pipeline when the output slot is free or being taken
    assign en          = !r_vld[STAGES-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_data  = r_out;

    // Valid bits and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_med_scale  <= MEDIAN_DEV_SCALE_RST;
            r_mean_scale <= MEAN_DEV_SCALE_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[STAGES-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MEDIAN_DEV_SCALE: r_med_scale  <= i_cfg_data;
                    CFG_MEAN_DEV_SCALE:   r_mean_scale <= i_cfg_data;
                    default:              r_med_scale  <= r_med_scale;
                endcase
            end
        end
    end

    // Stage 1: flag dead readings, pick live pair, first compare layer, sum all four
    always_comb begin
        n1_x[0] = i_in_data.reading_0;
        n1_x[1] = i_in_data.reading_1;
        n1_x[2] = i_in_data.reading_2;
        n1_x[3] = i_in_data.reading_3;
        dead_cnt = '0;
        live_cnt = '0;
        live0    = '0;
        live1    = '0;
        n1_sum   = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n1_dead[i] = (n1_x[i] == '0);
            dead_cnt   = dead_cnt + 3'(n1_dead[i]);
            n1_sum     = n1_sum + t_sum2'(n1_x[i]);
            if (!n1_dead[i] && live_cnt != 2'd2) begin
                if (live_cnt == 2'd0) begin
                    live0 = n1_x[i];
                end else begin
                    live1 = n1_x[i];
                end
                live_cnt = live_cnt + 2'd1;
            end
        end
        n1_lsum  = t_sum1'(live0) + t_sum1'(live1);
        n1_min01 = (n1_x[0] < n1_x[1]) ? n1_x[0] : n1_x[1];
        n1_max01 = (n1_x[0] < n1_x[1]) ? n1_x[1] : n1_x[0];
        n1_min23 = (n1_x[2] < n1_x[3]) ? n1_x[2] : n1_x[3];
        n1_max23 = (n1_x[2] < n1_x[3]) ? n1_x[3] : n1_x[2];
    end

    // Stage 2: median of the middle two sorted values, or of the live pair when exactly two readings are dead
    always_comb begin
        mid_a   = (r1_min01 > r1_min23) ? r1_min01 : r1_min23;
        mid_b   = (r1_max01 < r1_max23) ? r1_max01 : r1_max23;
        mid_sum = t_sum1'(mid_a) + t_sum1'(mid_b);
        n2_med  = r1_two ? r1_lsum[READING_WIDTH:1] : mid_sum[READING_WIDTH:1];
    end

    // Stage 4: first compare layer on deviations, sum of deviations from mean
    always_comb begin
        n4_dmin01 = (r3_dev[0] < r3_dev[1]) ? r3_dev[0] : r3_dev[1];
        n4_dmax01 = (r3_dev[0] < r3_dev[1]) ? r3_dev[1] : r3_dev[0];
        n4_dmin23 = (r3_dev[2] < r3_dev[3]) ? r3_dev[2] : r3_dev[3];
        n4_dmax23 = (r3_dev[2] < r3_dev[3]) ? r3_dev[3] : r3_dev[2];
        n4_adsum  = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n4_adsum = n4_adsum + t_dev_sum'(r3_adm[i]);
        end
    end

    // Stage 5: middle two deviations
    always_comb begin
        dmid_a   = (r4_dmin01 > r4_dmin23) ? r4_dmin01 : r4_dmin23;
        dmid_b   = (r4_dmax01 < r4_dmax23) ? r4_dmax01 : r4_dmax23;
        dmid_sum = {1'b0, dmid_a} + {1'b0, dmid_b};
    end

    // Stage 6: fall back to the mean absolute deviation when MAD is zero
    always_comb begin
        use_mad = (r5_mad != '0);
        spread  = use_mad ? r5_mad : r5_meanad;
        scale   = use_mad ? r_med_scale : r_mean_scale;
    end

    // Stage 8: outlier when 2 * 2^14 * dev > 7 * scale * spread; outliers and dead readings get the median
    always_comb begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            keep[i] = !r7_dead[i]
                   && (r7_quiet || !((t_prod7'(r7_dev[i]) << DEV_SHIFT) > r7_p7));
            cleaned[i] = keep[i] ? r7_x[i] : r7_med;
        end
        n_out.cleaned_0     = cleaned[0];
        n_out.cleaned_1     = cleaned[1];
        n_out.cleaned_2     = cleaned[2];
        n_out.cleaned_3     = cleaned[3];
        n_out.reliable_mask = keep;
        n_out.median_value  = r7_med;
    end

    // Payload registers: all stages move together on enable
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_x     <= n1_x;
            r1_dead  <= n1_dead;
            r1_two   <= (dead_cnt == 3'd2);
            r1_min01 <= n1_min01;
            r1_max01 <= n1_max01;
            r1_min23 <= n1_min23;
            r1_max23 <= n1_max23;
            r1_lsum  <= n1_lsum;
            r1_sum   <= n1_sum;
            // stage 2
            r2_x     <= r1_x;
            r2_dead  <= r1_dead;
            r2_med   <= n2_med;
            r2_mean  <= r1_sum[READING_WIDTH+1:2];
            // stage 3
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r3_dev[i] <= f_absdiff(r2_x[i], r2_med);
                r3_adm[i] <= f_absdiff(r2_x[i], r2_mean);
            end
            r3_x     <= r2_x;
            r3_dead  <= r2_dead;
            r3_med   <= r2_med;
            // stage 4
            r4_dmin01 <= n4_dmin01;
            r4_dmax01 <= n4_dmax01;
            r4_dmin23 <= n4_dmin23;
            r4_dmax23 <= n4_dmax23;
            r4_adsum  <= n4_adsum;
            r4_dev    <= r3_dev;
            r4_x      <= r3_x;
            r4_dead   <= r3_dead;
            r4_med    <= r3_med;
            // stage 5
            r5_mad    <= dmid_sum[READING_WIDTH:1];
            r5_meanad <= r4_adsum[READING_WIDTH+1:2];
            r5_dev    <= r4_dev;
            r5_x      <= r4_x;
            r5_dead   <= r4_dead;
            r5_med    <= r4_med;
            // stage 6
            r6_prod   <= t_prod'(scale) * t_prod'(spread);
            r6_quiet  <= !use_mad && (r5_meanad == '0);
            r6_dev    <= r5_dev;
            r6_x      <= r5_x;
            r6_dead   <= r5_dead;
            r6_med    <= r5_med;
            // stage 7
            r7_p7     <= (t_prod7'(r6_prod) << 3) - t_prod7'(r6_prod);
            r7_quiet  <= r6_quiet;
            r7_dev    <= r6_dev;
            r7_x      <= r6_x;
            r7_dead   <= r6_dead;
            r7_med    <= r6_med;
            // stage 8
            r_out     <= n_out;
        end
    end

endmodule
